@@ src/button_debounce_long_press_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and long-press unit
// Clocked assertions, disabled while the active-low reset is low; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define BDLP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bdlp assertion failed");

`define BDLP_ASSERT_NEVER(label, clk, rst_n, expr) \
    `BDLP_ASSERT(label, clk, rst_n, !(expr))

`else

`define BDLP_ASSERT(label, clk, rst_n, prop)

`define BDLP_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ src/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared widths, register indexes and reset values for the debounce unit.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int NUM_BUTTONS_DEF = 4;

    localparam int RAW_W   = 4;
    localparam int TICK_W  = 32;
    localparam int MASK_W  = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic                  ACTIVE_RST     = 1'b0;

endpackage

@@ src/button_debounce_long_press_unit.sv @@
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit
// A poll passes the input register, then the result register.
// Throughput: one poll per cycle when not stalled; per-button compare/update sits in one stage.
// The stall path is a single ready chain from m_axis_tready to s_axis_tready.
// Reset (sync, active low): levels released high, times zero, registers default.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_unit_assert.svh"

module button_debounce_long_press_unit #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // poll stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // raw_levels[3:0], now_tick[35:4]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // short[3:0], long[7:4], stable[11:8]
);

    localparam int RAW_W  = bdlp_pkg::RAW_W;
    localparam int TICK_W = bdlp_pkg::TICK_W;
    localparam int MASK_W = bdlp_pkg::MASK_W;

    // config registers
    logic [bdlp_pkg::CFG_DATA_W-1:0] r_debounce;
    logic [bdlp_pkg::CFG_DATA_W-1:0] r_long_press;
    logic                            r_active;

    // input stage
    logic              r_in_valid;
    logic [RAW_W-1:0]  r_in_raw;
    logic [TICK_W-1:0] r_in_now;

    // per-button state
    logic [NUM_BUTTONS-1:0] r_last_raw;
    logic [NUM_BUTTONS-1:0] r_stable;
    logic [NUM_BUTTONS-1:0] r_long_rep;
    logic [TICK_W-1:0]      r_change [NUM_BUTTONS];
    logic [TICK_W-1:0]      r_press  [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] n_last_raw;
    logic [NUM_BUTTONS-1:0] n_stable;
    logic [NUM_BUTTONS-1:0] n_long_rep;
    logic [TICK_W-1:0]      n_change [NUM_BUTTONS];
    logic [TICK_W-1:0]      n_press  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] n_short;
    logic [NUM_BUTTONS-1:0] n_long;

    // result stage
    logic              r_out_valid;
    logic [MASK_W-1:0] r_short;
    logic [MASK_W-1:0] r_long;
    logic [MASK_W-1:0] r_stable_out;

    logic                   w_advance;
    logic                   w_fire;
    logic [NUM_BUTTONS-1:0] w_raw;
    logic [MASK_W-1:0]      w_short4;
    logic [MASK_W-1:0]      w_long4;
    logic [MASK_W-1:0]      w_stable4;
    logic [MASK_W-1:0]      w_long_rep4;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    // map the 4-bit raw field onto NUM_BUTTONS, and state back onto 4-bit masks
    generate
        if (NUM_BUTTONS >= RAW_W) begin : g_wide
            assign w_raw       = NUM_BUTTONS'(r_in_raw);
            assign w_short4    = n_short[MASK_W-1:0];
            assign w_long4     = n_long[MASK_W-1:0];
            assign w_stable4   = n_stable[MASK_W-1:0];
            assign w_long_rep4 = r_long_rep[MASK_W-1:0];
        end else begin : g_narrow
            assign w_raw       = r_in_raw[NUM_BUTTONS-1:0];
            assign w_short4    = {{(MASK_W-NUM_BUTTONS){1'b0}}, n_short};
            assign w_long4     = {{(MASK_W-NUM_BUTTONS){1'b0}}, n_long};
            assign w_stable4   = {{(MASK_W-NUM_BUTTONS){1'b0}}, n_stable};
            assign w_long_rep4 = {{(MASK_W-NUM_BUTTONS){1'b0}}, r_long_rep};
        end
    endgenerate

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bdlp_pkg::DEBOUNCE_RST;
            r_long_press <= bdlp_pkg::LONG_PRESS_RST;
            r_active     <= bdlp_pkg::ACTIVE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bdlp_pkg::CFG_DEBOUNCE:     r_debounce   <= i_cfg_data;
                bdlp_pkg::CFG_LONG_PRESS:   r_long_press <= i_cfg_data;
                bdlp_pkg::CFG_ACTIVE_LEVEL: r_active     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_raw <= s_axis_tdata[RAW_W-1:0];
            r_in_now <= s_axis_tdata[RAW_W+TICK_W-1:RAW_W];
        end
    end

    // per-button update: change time, debounce, then long-press check
    always_comb begin
        logic              raw;
        logic [TICK_W-1:0] ct;
        logic [TICK_W-1:0] pt;
        logic              flip;
        logic              st_new;
        logic              press;
        logic              lr;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            raw    = w_raw[i];
            ct     = (raw != r_last_raw[i]) ? r_in_now : r_change[i];
            flip   = (raw != r_stable[i]) &&
                     ((r_in_now - ct) >= {{(TICK_W-bdlp_pkg::CFG_DATA_W){1'b0}}, r_debounce});
            st_new = flip ? raw : r_stable[i];
            press  = flip && (raw == r_active);
            pt     = press ? r_in_now : r_press[i];
            lr     = press ? 1'b0 : r_long_rep[i];

            n_short[i]    = flip && (raw != r_active) && !r_long_rep[i];
            n_long[i]     = (st_new == r_active) && !lr &&
                            ((r_in_now - pt) >=
                             {{(TICK_W-bdlp_pkg::CFG_DATA_W){1'b0}}, r_long_press});
            n_last_raw[i] = raw;
            n_change[i]   = ct;
            n_stable[i]   = st_new;
            n_press[i]    = pt;
            n_long_rep[i] = lr || n_long[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '1;
            r_stable   <= '1;
            r_long_rep <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_change[i] <= '0;
                r_press[i]  <= '0;
            end
        end else if (w_fire) begin
            r_last_raw <= n_last_raw;
            r_stable   <= n_stable;
            r_long_rep <= n_long_rep;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_change[i] <= n_change[i];
                r_press[i]  <= n_press[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_short      <= w_short4;
            r_long       <= w_long4;
            r_stable_out <= w_stable4;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bdlp_pkg::OUT_TDATA_W-3*MASK_W){1'b0}},
                            r_stable_out, r_long, r_short};

    // a release and a long press cannot be reported for the same button at once
    `BDLP_ASSERT_NEVER(a_short_long_excl, i_clk, i_rst_n, r_out_valid && |(r_short & r_long))
    // every long report leaves the button marked as reported
    `BDLP_ASSERT(a_long_marks, i_clk, i_rst_n, w_fire |=> ((w_long_rep4 & r_long) == r_long))
    // input side only stalls when both stages hold data
    `BDLP_ASSERT(a_stall_full, i_clk, i_rst_n, !s_axis_tready |-> (r_in_valid && r_out_valid))

endmodule

@@ tb/sv/bdlp_event_checker.sv @@
// ----------------------------------------------------------------------------
// bdlp_event_checker
// Watches the config port and both streams of the debounce unit. Each poll
// transaction is run through a per-button debounce/long-press predictor, and
// the predicted masks are queued. Every result transaction is then compared
// field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module bdlp_event_checker #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_poll_valid,
    input  logic                                i_poll_ready,
    input  logic [bdlp_pkg::IN_TDATA_W-1:0]     i_poll_data,   // raw[3:0], tick[35:4]
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [bdlp_pkg::OUT_TDATA_W-1:0]    i_res_data,    // short[3:0], long[7:4], stable[11:8]
    output int                                  o_pending,
    output int                                  o_errors
);

    localparam int MASK_W = bdlp_pkg::MASK_W;
    localparam int TICK_W = bdlp_pkg::TICK_W;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [MASK_W-1:0] stable_m;
        logic [MASK_W-1:0] long_m;
        logic [MASK_W-1:0] short_m;
    } poll_masks_t;

    logic [bdlp_pkg::CFG_DATA_W-1:0] debounce_ticks;
    logic [bdlp_pkg::CFG_DATA_W-1:0] long_press_ticks;
    logic                            active_level;

    logic [NUM_BUTTONS-1:0] btn_last_raw;
    logic [NUM_BUTTONS-1:0] btn_stable;
    logic [NUM_BUTTONS-1:0] btn_long_done;
    logic [TICK_W-1:0]      btn_change_tick [NUM_BUTTONS];
    logic [TICK_W-1:0]      btn_press_tick  [NUM_BUTTONS];

    poll_masks_t expected_masks_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_errors++;
        if (o_errors <= PRINT_CAP)
            $display("%0t bdlp check: %s got %h want %h", $time, what, got, want);
    endtask

    function automatic poll_masks_t debounce_poll(input logic [MASK_W-1:0] raw,
                                                  input logic [TICK_W-1:0] now);
        poll_masks_t r;
        logic [TICK_W-1:0] held;
        logic bit_raw;
        r = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            bit_raw = (b < MASK_W) ? raw[b] : 1'b0;
            if (bit_raw != btn_last_raw[b]) begin
                btn_last_raw[b]    = bit_raw;
                btn_change_tick[b] = now;
            end
            held = now - btn_change_tick[b];
            if (bit_raw != btn_stable[b] && held >= TICK_W'(debounce_ticks)) begin
                btn_stable[b] = bit_raw;
                if (btn_stable[b] == active_level) begin
                    btn_press_tick[b] = now;
                    btn_long_done[b]  = 1'b0;
                end else if (!btn_long_done[b] && b < MASK_W) begin
                    r.short_m[b] = 1'b1;
                end
            end
            held = now - btn_press_tick[b];
            if (btn_stable[b] == active_level && !btn_long_done[b] &&
                held >= TICK_W'(long_press_ticks)) begin
                btn_long_done[b] = 1'b1;
                if (b < MASK_W)
                    r.long_m[b] = 1'b1;
            end
            if (b < MASK_W)
                r.stable_m[b] = btn_stable[b];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        poll_masks_t want_m;
        poll_masks_t got_m;
        if (!i_rst_n) begin
            debounce_ticks   = bdlp_pkg::DEBOUNCE_RST;
            long_press_ticks = bdlp_pkg::LONG_PRESS_RST;
            active_level     = bdlp_pkg::ACTIVE_RST;
            btn_last_raw     = '1;
            btn_stable       = '1;
            btn_long_done    = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                btn_change_tick[b] = '0;
                btn_press_tick[b]  = '0;
            end
            expected_masks_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bdlp_pkg::CFG_DEBOUNCE:     debounce_ticks   = i_cfg_data;
                    bdlp_pkg::CFG_LONG_PRESS:   long_press_ticks = i_cfg_data;
                    bdlp_pkg::CFG_ACTIVE_LEVEL: active_level     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_poll_valid && i_poll_ready)
                expected_masks_q.push_back(debounce_poll(i_poll_data[MASK_W-1:0],
                                                         i_poll_data[MASK_W +: TICK_W]));
            if (i_res_valid && i_res_ready) begin
                got_m = i_res_data[3*MASK_W-1:0];
                if (expected_masks_q.size() == 0) begin
                    report_mismatch("result with no poll pending", 32'(got_m), '0);
                end else begin
                    want_m = expected_masks_q.pop_front();
                    if (got_m.short_m !== want_m.short_m)
                        report_mismatch("short_mask", 32'(got_m.short_m), 32'(want_m.short_m));
                    if (got_m.long_m !== want_m.long_m)
                        report_mismatch("long_mask", 32'(got_m.long_m), 32'(want_m.long_m));
                    if (got_m.stable_m !== want_m.stable_m)
                        report_mismatch("stable_levels", 32'(got_m.stable_m),
                                        32'(want_m.stable_m));
                end
            end
        end
        o_pending = expected_masks_q.size();
    end

endmodule

@@ tb/sv/tb_button_debounce_long_press_unit.sv @@
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_unit
// Drives polls into the debounce unit: a directed opening (reset levels,
// active-high at reset, zero thresholds, tick wrap) and then random phases
// over several register settings, with bouncing buttons, tick jumps and
// random idle cycles on both streams. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                                i_cfg_we;
    logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_addr;
    logic [bdlp_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [bdlp_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // raw_levels[3:0], now_tick[35:4]
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [bdlp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // short[3:0], long[7:4], stable[11:8]

    int pending_cnt;
    int fail_cnt;

    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    logic [3:0]  cur_raw;
    logic [31:0] cur_tick;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    button_debounce_long_press_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bdlp_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_poll_valid (s_axis_tvalid),
        .i_poll_ready (s_axis_tready),
        .i_poll_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_pending    (pending_cnt),
        .o_errors     (fail_cnt)
    );

    task automatic send_poll(input logic [3:0] raw, input logic [31:0] tick);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 29) == 0)
            tx_steady = !tx_steady;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, tick, raw};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlp_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] deb, input logic [15:0] lp,
                             input logic act, input int n_items, input int flip_pct);
        int span;
        int pick;
        settle();
        cfg_write(bdlp_pkg::CFG_DEBOUNCE, deb);
        cfg_write(bdlp_pkg::CFG_LONG_PRESS, lp);
        cfg_write(bdlp_pkg::CFG_ACTIVE_LEVEL, {15'b0, act});
        span = ((deb > lp) ? deb : lp) / 3 + 2;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                settle();
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                cur_raw = 4'($urandom_range(0, 15));
            end else begin
                for (int b = 0; b < 4; b++)
                    if ($urandom_range(0, 99) < flip_pct)
                        cur_raw[b] = !cur_raw[b];
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cur_tick = cur_tick + $urandom;
            else
                cur_tick = cur_tick + $urandom_range(0, span);
            send_poll(cur_raw, cur_tick);
        end
    endtask

    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 29) == 0)
                rx_steady = !rx_steady;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cur_raw       = 4'hF;
        cur_tick      = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, buttons released: nothing happens
        send_poll(4'hF, 32'd0);
        send_poll(4'hF, 32'd100);
        send_poll(4'hF, 32'd1500);
        // active high with untouched reset state: released level counts as held
        settle();
        cfg_write(bdlp_pkg::CFG_ACTIVE_LEVEL, 16'd1);
        send_poll(4'hF, 32'd2000);
        send_poll(4'h0, 32'd2010);
        send_poll(4'h0, 32'd2070);
        // zero thresholds: press and long press in one poll
        settle();
        cfg_write(bdlp_pkg::CFG_DEBOUNCE, 16'd0);
        cfg_write(bdlp_pkg::CFG_LONG_PRESS, 16'd0);
        send_poll(4'h5, 32'd3000);
        send_poll(4'h0, 32'd3000);
        // short press, then long press across the tick wrap
        settle();
        cfg_write(bdlp_pkg::CFG_LONG_PRESS, 16'd5);
        send_poll(4'hF, 32'd4000);
        send_poll(4'h0, 32'd4002);
        send_poll(4'hF, 32'hFFFF_FFFE);
        send_poll(4'hF, 32'h0000_0004);
        send_poll(4'hA, 32'h0000_0006);
        cur_raw  = 4'hA;
        cur_tick = 32'h0000_0006;

        run_phase(16'd50,    16'd1000,  1'b0, 155, 15);
        run_phase(16'd0,     16'd0,     1'b1, 155, 20);
        run_phase(16'd65535, 16'd65535, 1'b0, 155, 12);
        run_phase(16'd65535, 16'd0,     1'b1, 155, 15);
        run_phase(16'd0,     16'd65535, 1'b0, 155, 10);
        run_phase(16'($urandom_range(1, 400)), 16'($urandom_range(0, 3000)),
                  1'($urandom_range(0, 1)), 155, 15);
        run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 20000)),
                  1'($urandom_range(0, 1)), 155, 18);
        run_phase(16'd3,     16'd12,    1'b1, 155, 25);

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("tb_button_debounce_long_press_unit: done, clean");
        else
            $display("tb_button_debounce_long_press_unit: done, errors");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("tb_button_debounce_long_press_unit: done, errors");
        $finish;
    end

endmodule
